/* design/rgbwb_pkg.sv */
// Shared constants, register indexes and channel scaling for the RGB gain unit.
package rgbwb_pkg;

    localparam int GAIN_FRAC_BITS = 16;
    localparam int FACTOR_W       = GAIN_FRAC_BITS + 1;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 6;
    localparam int PROD_W         = GAIN_W + FACTOR_W;
    localparam int EXP_SHIFT      = GAIN_FRAC_BITS - 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPOSURE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMPERATURE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TINT        = 2'd2;

    localparam logic [15:0] EXP_UNITY   = 16'd256;
    localparam logic [15:0] EXP_MIN     = 16'd64;
    localparam logic [15:0] EXP_MAX     = 16'd8192;
    localparam logic [14:0] WARM_PIVOT  = 15'd5500;
    localparam logic [14:0] WARM_SPAN   = 15'd4500;
    localparam logic [10:0] TINT_SPAN   = 11'd200;
    localparam int          WARM_DEN    = 90000;
    localparam int          TINT_DEN    = 10000;

    // Both divisors carry a factor of 16 that the fixed point scale cancels exactly;
    // the rest is a reciprocal multiply, exact over the whole operand range.
    localparam int PRE_SHIFT   = 4;
    localparam int WARM_X_W    = GAIN_FRAC_BITS + 11;
    localparam int TINT_X_W    = GAIN_FRAC_BITS + 7;
    localparam int WARM_DIV    = WARM_DEN >> PRE_SHIFT;
    localparam int TINT_DIV    = TINT_DEN >> PRE_SHIFT;
    localparam int WARM_SHIFT  = WARM_X_W + 13;
    localparam int TINT_SHIFT  = TINT_X_W + 10;
    localparam int WARM_PROD_W = WARM_SHIFT + GAIN_FRAC_BITS;
    localparam int TINT_PROD_W = TINT_SHIFT + GAIN_FRAC_BITS;
    localparam logic [WARM_X_W:0] WARM_RECIP =
        (WARM_X_W + 1)'(((64'd1 << WARM_SHIFT) + 64'(WARM_DIV) - 64'd1) / 64'(WARM_DIV));
    localparam logic [TINT_X_W:0] TINT_RECIP =
        (TINT_X_W + 1)'(((64'd1 << TINT_SHIFT) + 64'(TINT_DIV) - 64'd1) / 64'(TINT_DIV));
    localparam logic [WARM_X_W-1:0] WARM_BIAS = WARM_X_W'((WARM_DEN / 2) >> PRE_SHIFT);
    localparam logic [TINT_X_W-1:0] TINT_BIAS = TINT_X_W'((TINT_DEN / 2) >> PRE_SHIFT);

    localparam logic [FACTOR_W-1:0] GAIN_ONE  = FACTOR_W'(1) << GAIN_FRAC_BITS;
    localparam logic [PROD_W-1:0]   PROD_HALF = PROD_W'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic [7:0]          CHANNEL_MAX = 8'd255;

    function automatic logic [7:0] scale_byte(input logic [7:0] c, input logic [GAIN_W-1:0] g);
        logic [GAIN_W+7:0] prod;
        logic [GAIN_W+7:0] rounded;
        logic [GAIN_W+7:0] shifted;
        prod    = (GAIN_W + 8)'(c) * (GAIN_W + 8)'(g);
        rounded = prod + ((GAIN_W + 8)'(1) << (GAIN_FRAC_BITS - 1));
        shifted = rounded >> GAIN_FRAC_BITS;
        scale_byte = (shifted > (GAIN_W + 8)'(CHANNEL_MAX)) ? CHANNEL_MAX : shifted[7:0];
    endfunction

endpackage

/* design/rgb_exposure_white_balance_gain_unit.sv */
// RGB exposure and white balance gain unit: per-pixel channel gains from three registers.
// A pixel passes an input register and an output register; one pixel per cycle unless busy.
// A register write starts a gain update: operand load, a reciprocal multiply step for
// the warmth and tint factors, five shared gain multiplies; busy is high meanwhile.
// The receiver cannot stall; each result shows for one cycle with done.
// Reset clears the registers to 256/0/0 (bypass), the strobes and the update sequencer.
module rgb_exposure_white_balance_gain_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [7:0]                         in_red,
    input  logic [7:0]                         in_green,
    input  logic [7:0]                         in_blue,
    input  logic [7:0]                         in_alpha,
    output logic                               done,
    output logic [7:0]                         out_red,
    output logic [7:0]                         out_green,
    output logic [7:0]                         out_blue,
    output logic [7:0]                         out_alpha,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rgbwb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rgbwb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_RECIP,
        S_MR1,
        S_MB1,
        S_MG,
        S_MR2,
        S_MB2
    } seq_state_t;

    seq_state_t state_reg;

    logic [15:0]        exposure_gain_reg;
    logic [14:0]        color_temperature_reg;
    logic signed [10:0] color_tint_reg;

    logic [rgbwb_pkg::WARM_X_W-1:0]       warm_x_reg;
    logic [rgbwb_pkg::TINT_X_W-1:0]       tint_x_reg;
    logic [rgbwb_pkg::GAIN_FRAC_BITS-1:0] warm_q_reg;
    logic [rgbwb_pkg::GAIN_FRAC_BITS-1:0] tint_p_reg;
    logic [rgbwb_pkg::GAIN_W-1:0] gain_red_reg;
    logic [rgbwb_pkg::GAIN_W-1:0] gain_green_reg;
    logic [rgbwb_pkg::GAIN_W-1:0] gain_blue_reg;

    logic       pix_valid_reg;
    logic [7:0] pix_red_reg;
    logic [7:0] pix_green_reg;
    logic [7:0] pix_blue_reg;
    logic [7:0] pix_alpha_reg;

    logic       done_reg;
    logic [7:0] out_red_reg;
    logic [7:0] out_green_reg;
    logic [7:0] out_blue_reg;
    logic [7:0] out_alpha_reg;

    logic cfg_write;
    logic accept;
    logic warm;
    logic warm_neg;
    logic bypass;
    logic tint_neg;
    logic tint_pos;
    logic [14:0] warm_abs;
    logic [12:0] warm_mag;
    logic [14:0] warm_mag7;
    logic [10:0] tint_abs;
    logic [7:0]  tint_mag;
    logic [10:0] tint_mag9;
    logic [13:0] exp_clamped;
    logic [rgbwb_pkg::GAIN_W-1:0]   exp_gain;
    logic [rgbwb_pkg::WARM_X_W-1:0] warm_x;
    logic [rgbwb_pkg::TINT_X_W-1:0] tint_x;

    logic [rgbwb_pkg::WARM_PROD_W-1:0] warm_prod;
    logic [rgbwb_pkg::TINT_PROD_W-1:0] tint_prod;

    logic [rgbwb_pkg::FACTOR_W-1:0] warm_red_f;
    logic [rgbwb_pkg::FACTOR_W-1:0] warm_blue_f;
    logic [rgbwb_pkg::FACTOR_W-1:0] tint_up_f;
    logic [rgbwb_pkg::FACTOR_W-1:0] tint_down_f;
    logic [rgbwb_pkg::GAIN_W-1:0]   mul_a;
    logic [rgbwb_pkg::FACTOR_W-1:0] mul_b;
    logic [rgbwb_pkg::PROD_W-1:0]   mul_prod;
    logic [rgbwb_pkg::PROD_W-1:0]   mul_round;
    logic [rgbwb_pkg::GAIN_W-1:0]   gain_next;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready
                    && (cfg_index == rgbwb_pkg::CFG_EXPOSURE
                     || cfg_index == rgbwb_pkg::CFG_TEMPERATURE
                     || cfg_index == rgbwb_pkg::CFG_TINT);
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        warm     = (color_temperature_reg != 15'd0)
                && (color_temperature_reg != rgbwb_pkg::WARM_PIVOT);
        warm_neg = color_temperature_reg > rgbwb_pkg::WARM_PIVOT;
        warm_abs = warm_neg ? color_temperature_reg - rgbwb_pkg::WARM_PIVOT
                            : rgbwb_pkg::WARM_PIVOT - color_temperature_reg;
        if (!warm)
        begin
            warm_mag = 13'd0;
        end
        else if (warm_abs > rgbwb_pkg::WARM_SPAN)
        begin
            warm_mag = rgbwb_pkg::WARM_SPAN[12:0];
        end
        else
        begin
            warm_mag = warm_abs[12:0];
        end
        warm_mag7 = 15'(warm_mag) * 15'd7;
        warm_x    = {warm_mag7, {(rgbwb_pkg::GAIN_FRAC_BITS - rgbwb_pkg::PRE_SHIFT){1'b0}}}
                  + rgbwb_pkg::WARM_BIAS;

        tint_neg  = color_tint_reg < 0;
        tint_pos  = !tint_neg && (color_tint_reg != 11'sd0);
        tint_abs  = tint_neg ? 11'(-color_tint_reg) : 11'(color_tint_reg);
        tint_mag  = (tint_abs > rgbwb_pkg::TINT_SPAN) ? rgbwb_pkg::TINT_SPAN[7:0]
                                                      : tint_abs[7:0];
        tint_mag9 = 11'(tint_mag) * 11'd9;
        tint_x    = {tint_mag9, {(rgbwb_pkg::GAIN_FRAC_BITS - rgbwb_pkg::PRE_SHIFT){1'b0}}}
                  + rgbwb_pkg::TINT_BIAS;

        if (exposure_gain_reg < rgbwb_pkg::EXP_MIN)
        begin
            exp_clamped = rgbwb_pkg::EXP_MIN[13:0];
        end
        else if (exposure_gain_reg > rgbwb_pkg::EXP_MAX)
        begin
            exp_clamped = rgbwb_pkg::EXP_MAX[13:0];
        end
        else
        begin
            exp_clamped = exposure_gain_reg[13:0];
        end
        exp_gain = {exp_clamped, {rgbwb_pkg::EXP_SHIFT{1'b0}}};

        bypass = (exposure_gain_reg == rgbwb_pkg::EXP_UNITY) && !warm
              && (color_tint_reg == 11'sd0);
    end

    always_comb
    begin
        warm_prod = rgbwb_pkg::WARM_PROD_W'(warm_x_reg)
                  * rgbwb_pkg::WARM_PROD_W'(rgbwb_pkg::WARM_RECIP);
        tint_prod = rgbwb_pkg::TINT_PROD_W'(tint_x_reg)
                  * rgbwb_pkg::TINT_PROD_W'(rgbwb_pkg::TINT_RECIP);
    end

    always_comb
    begin
        warm_red_f  = warm_neg ? rgbwb_pkg::GAIN_ONE - rgbwb_pkg::FACTOR_W'(warm_q_reg)
                               : rgbwb_pkg::GAIN_ONE + rgbwb_pkg::FACTOR_W'(warm_q_reg);
        warm_blue_f = warm_neg ? rgbwb_pkg::GAIN_ONE + rgbwb_pkg::FACTOR_W'(warm_q_reg)
                               : rgbwb_pkg::GAIN_ONE - rgbwb_pkg::FACTOR_W'(warm_q_reg);
        tint_up_f   = tint_pos ? rgbwb_pkg::GAIN_ONE + rgbwb_pkg::FACTOR_W'(tint_p_reg)
                               : rgbwb_pkg::GAIN_ONE - rgbwb_pkg::FACTOR_W'(tint_p_reg);
        tint_down_f = tint_pos ? rgbwb_pkg::GAIN_ONE - rgbwb_pkg::FACTOR_W'(tint_p_reg)
                               : rgbwb_pkg::GAIN_ONE + rgbwb_pkg::FACTOR_W'(tint_p_reg);
        unique case (state_reg)
            S_MR1:
            begin
                mul_a = exp_gain;
                mul_b = warm_red_f;
            end
            S_MB1:
            begin
                mul_a = exp_gain;
                mul_b = warm_blue_f;
            end
            S_MG:
            begin
                mul_a = exp_gain;
                mul_b = tint_down_f;
            end
            S_MR2:
            begin
                mul_a = gain_red_reg;
                mul_b = tint_up_f;
            end
            S_MB2:
            begin
                mul_a = gain_blue_reg;
                mul_b = tint_up_f;
            end
            default:
            begin
                mul_a = exp_gain;
                mul_b = rgbwb_pkg::GAIN_ONE;
            end
        endcase
        mul_prod  = rgbwb_pkg::PROD_W'(mul_a) * rgbwb_pkg::PROD_W'(mul_b);
        mul_round = (mul_prod + rgbwb_pkg::PROD_HALF) >> rgbwb_pkg::GAIN_FRAC_BITS;
        gain_next = mul_round[rgbwb_pkg::GAIN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_IDLE;
            exposure_gain_reg     <= rgbwb_pkg::EXP_UNITY;
            color_temperature_reg <= 15'd0;
            color_tint_reg        <= 11'sd0;
            warm_x_reg            <= '0;
            tint_x_reg            <= '0;
            warm_q_reg            <= '0;
            tint_p_reg            <= '0;
            gain_red_reg          <= '0;
            gain_green_reg        <= '0;
            gain_blue_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    rgbwb_pkg::CFG_EXPOSURE:    exposure_gain_reg     <= cfg_data;
                    rgbwb_pkg::CFG_TEMPERATURE: color_temperature_reg <= cfg_data[14:0];
                    rgbwb_pkg::CFG_TINT:        color_tint_reg        <= signed'(cfg_data[10:0]);
                    default:                    ;
                endcase
            end
            if (cfg_write)
            begin
                state_reg <= S_LOAD;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE: ;
                    S_LOAD:
                    begin
                        warm_x_reg <= warm_x;
                        tint_x_reg <= tint_x;
                        state_reg  <= S_RECIP;
                    end
                    S_RECIP:
                    begin
                        warm_q_reg <= warm_prod[rgbwb_pkg::WARM_SHIFT +: rgbwb_pkg::GAIN_FRAC_BITS];
                        tint_p_reg <= tint_prod[rgbwb_pkg::TINT_SHIFT +: rgbwb_pkg::GAIN_FRAC_BITS];
                        state_reg  <= S_MR1;
                    end
                    S_MR1:
                    begin
                        gain_red_reg <= gain_next;
                        state_reg    <= S_MB1;
                    end
                    S_MB1:
                    begin
                        gain_blue_reg <= gain_next;
                        state_reg     <= S_MG;
                    end
                    S_MG:
                    begin
                        gain_green_reg <= gain_next;
                        state_reg      <= S_MR2;
                    end
                    S_MR2:
                    begin
                        gain_red_reg <= gain_next;
                        state_reg    <= S_MB2;
                    end
                    S_MB2:
                    begin
                        gain_blue_reg <= gain_next;
                        state_reg     <= S_IDLE;
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= accept;
            done_reg      <= pix_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_red_reg   <= in_red;
            pix_green_reg <= in_green;
            pix_blue_reg  <= in_blue;
            pix_alpha_reg <= in_alpha;
        end
        if (pix_valid_reg)
        begin
            if (bypass)
            begin
                out_red_reg   <= pix_red_reg;
                out_green_reg <= pix_green_reg;
                out_blue_reg  <= pix_blue_reg;
                out_alpha_reg <= pix_alpha_reg;
            end
            else
            begin
                out_red_reg   <= rgbwb_pkg::scale_byte(pix_red_reg, gain_red_reg);
                out_green_reg <= rgbwb_pkg::scale_byte(pix_green_reg, gain_green_reg);
                out_blue_reg  <= rgbwb_pkg::scale_byte(pix_blue_reg, gain_blue_reg);
                out_alpha_reg <= rgbwb_pkg::CHANNEL_MAX;
            end
        end
    end

    assign done      = done_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign out_alpha = out_alpha_reg;

endmodule

/* design/rgbwb_checker.sv */
// Port-level checks for the RGB gain unit, bound to its top level.
module rgbwb_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [rgbwb_pkg::CFG_INDEX_W-1:0] cfg_index
);

    logic accept;
    logic cfg_write;

    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready
                    && (cfg_index == rgbwb_pkg::CFG_EXPOSURE
                     || cfg_index == rgbwb_pkg::CFG_TEMPERATURE
                     || cfg_index == rgbwb_pkg::CFG_TINT);

    a_request_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted request produced no result two cycles later");

    a_done_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result without a request two cycles earlier");

    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> busy)
        else $error("register write did not start a gain update");

endmodule

bind rgb_exposure_white_balance_gain_unit rgbwb_checker u_rgbwb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);

/* tb/testbench.sv */
// Testbench for the RGB gain unit: directed and random pixels checked by a gain predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rgbwb_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    class wb_gain_checker;
        logic [15:0]        exposure;
        logic [14:0]        temperature;
        logic signed [10:0] tint;
        pixel_t             expected_pixels[$];
        int unsigned        failures;

        function new();
            exposure    = rgbwb_pkg::EXP_UNITY;
            temperature = '0;
            tint        = '0;
            failures    = 0;
        endfunction

        function void write_register(logic [rgbwb_pkg::CFG_INDEX_W-1:0] idx,
                                     logic [rgbwb_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rgbwb_pkg::CFG_EXPOSURE:    exposure = data;
                rgbwb_pkg::CFG_TEMPERATURE: temperature = data[14:0];
                rgbwb_pkg::CFG_TINT:        tint = data[10:0];
                default:                    ;
            endcase
        endfunction

        function longint unsigned mul_round(longint unsigned g, longint unsigned f);
            return (g * f + (64'd1 << (rgbwb_pkg::GAIN_FRAC_BITS - 1)))
                   >> rgbwb_pkg::GAIN_FRAC_BITS;
        endfunction

        function logic [7:0] scale_channel(logic [7:0] c, longint unsigned g);
            longint unsigned v;
            v = mul_round(64'(c), g);
            return (v > 64'd255) ? 8'd255 : 8'(v);
        endfunction

        function pixel_t apply_gains(pixel_t px);
            longint unsigned one, e, gr, gg, gb, mag, q, up, down;
            longint          d, t;
            bit              warm, tinted;
            pixel_t          res;
            one    = 64'd1 << rgbwb_pkg::GAIN_FRAC_BITS;
            warm   = temperature != 15'd0 && temperature != rgbwb_pkg::WARM_PIVOT;
            tinted = tint != 11'sd0;
            if (exposure == rgbwb_pkg::EXP_UNITY && !warm && !tinted)
                return px;
            e = 64'(exposure);
            if (e < 64'(rgbwb_pkg::EXP_MIN))
                e = 64'(rgbwb_pkg::EXP_MIN);
            if (e > 64'(rgbwb_pkg::EXP_MAX))
                e = 64'(rgbwb_pkg::EXP_MAX);
            e  = e << (rgbwb_pkg::GAIN_FRAC_BITS - 8);
            gr = e;
            gg = e;
            gb = e;
            if (warm)
            begin
                d = longint'(rgbwb_pkg::WARM_PIVOT) - longint'(temperature);
                if (d > longint'(rgbwb_pkg::WARM_SPAN))
                    d = longint'(rgbwb_pkg::WARM_SPAN);
                if (d < -longint'(rgbwb_pkg::WARM_SPAN))
                    d = -longint'(rgbwb_pkg::WARM_SPAN);
                mag = (d < 0) ? -d : d;
                q   = (mag * 64'd7 * one + 64'(rgbwb_pkg::WARM_DEN) / 64'd2)
                    / 64'(rgbwb_pkg::WARM_DEN);
                if (d >= 0)
                begin
                    gr = mul_round(gr, one + q);
                    gb = mul_round(gb, one - q);
                end
                else
                begin
                    gr = mul_round(gr, one - q);
                    gb = mul_round(gb, one + q);
                end
            end
            if (tinted)
            begin
                t = longint'(tint);
                if (t > longint'(rgbwb_pkg::TINT_SPAN))
                    t = longint'(rgbwb_pkg::TINT_SPAN);
                if (t < -longint'(rgbwb_pkg::TINT_SPAN))
                    t = -longint'(rgbwb_pkg::TINT_SPAN);
                mag  = (t < 0) ? -t : t;
                q    = (mag * 64'd9 * one + 64'(rgbwb_pkg::TINT_DEN) / 64'd2)
                     / 64'(rgbwb_pkg::TINT_DEN);
                up   = (t > 0) ? one + q : one - q;
                down = (t > 0) ? one - q : one + q;
                gr   = mul_round(gr, up);
                gb   = mul_round(gb, up);
                gg   = mul_round(gg, down);
            end
            res.red   = scale_channel(px.red, gr);
            res.green = scale_channel(px.green, gg);
            res.blue  = scale_channel(px.blue, gb);
            res.alpha = rgbwb_pkg::CHANNEL_MAX;
            return res;
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            failures++;
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        endtask

        function void note_pixel(pixel_t px);
            expected_pixels.push_back(apply_gains(px));
        endfunction

        task check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.red !== want.red)
                report_mismatch("red", 32'(got.red), 32'(want.red));
            if (got.green !== want.green)
                report_mismatch("green", 32'(got.green), 32'(want.green));
            if (got.blue !== want.blue)
                report_mismatch("blue", 32'(got.blue), 32'(want.blue));
            if (got.alpha !== want.alpha)
                report_mismatch("alpha", 32'(got.alpha), 32'(want.alpha));
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [7:0]                        in_red = '0;
    logic [7:0]                        in_green = '0;
    logic [7:0]                        in_blue = '0;
    logic [7:0]                        in_alpha = '0;
    logic                              done;
    logic [7:0]                        out_red;
    logic [7:0]                        out_green;
    logic [7:0]                        out_blue;
    logic [7:0]                        out_alpha;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [rgbwb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rgbwb_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    wb_gain_checker gains = new();

    rgb_exposure_white_balance_gain_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .done      (done),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                gains.check_pixel({out_red, out_green, out_blue, out_alpha});
            if (start && !busy)
                gains.note_pixel({in_red, in_green, in_blue, in_alpha});
        end
    end

    task automatic send_pixel(input pixel_t px, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        {in_red, in_green, in_blue, in_alpha} <= px;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (gains.pending() != 0)
            @(posedge clk);
    endtask

    // hold valid across back-to-back writes; caller drops it
    task automatic write_register(input logic [rgbwb_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [rgbwb_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        gains.write_register(idx, data);
    endtask

    task automatic set_gains(input logic [15:0] exp_v, input logic [15:0] temp_v,
                             input logic [15:0] tint_v, input bit poke_unused);
        drain();
        if (poke_unused)
            write_register(CFG_UNUSED, 16'($urandom));
        write_register(rgbwb_pkg::CFG_EXPOSURE, exp_v);
        write_register(rgbwb_pkg::CFG_TEMPERATURE, temp_v);
        write_register(rgbwb_pkg::CFG_TINT, tint_v);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_exposure();
        case ($urandom_range(5))
            0: return rgbwb_pkg::EXP_UNITY;
            1: return 16'd0;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(rgbwb_pkg::EXP_MIN, rgbwb_pkg::EXP_MAX));
            4: return 16'($urandom_range(0, 600));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_temperature();
        logic [14:0] k;
        case ($urandom_range(4))
            0: k = '0;
            1: k = rgbwb_pkg::WARM_PIVOT;
            2: k = 15'($urandom_range(0, 20000));
            3: k = 15'($urandom_range(5490, 5510));
            default: k = 15'($urandom);
        endcase
        return {1'($urandom), k};
    endfunction

    function automatic logic [15:0] pick_tint();
        logic [10:0] v;
        case ($urandom_range(4))
            0: v = '0;
            1: v = 11'(int'($urandom_range(0, 2000)) - 1000);
            2: v = 11'(int'($urandom_range(0, 10)) - 5);
            3: v = 11'(int'($urandom_range(0, 500)) - 250);
            default: v = 11'($urandom);
        endcase
        return {5'($urandom), v};
    endfunction

    initial
    begin
        int idle_pct;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(32'h00000000, 29);
        send_pixel(32'hFFFFFFFF, 29);
        send_pixel(32'h55AA0FF0, 29);

        set_gains(16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_pixel(32'hFFFFFF00, 29);
        send_pixel(32'h01020304, 29);
        send_pixel(32'h00000000, 29);

        set_gains(16'd0, 16'd20000, 16'(-16'sd1000), 1'b0);
        send_pixel(32'hFFFFFFFF, 29);
        send_pixel(32'h80808080, 29);
        send_pixel(32'h7F3C9912, 29);

        set_gains(rgbwb_pkg::EXP_UNITY, 16'(rgbwb_pkg::WARM_PIVOT), 16'd0, 1'b1);
        send_pixel(32'h12345678, 29);
        send_pixel(32'hEDCBA987, 29);

        set_gains(rgbwb_pkg::EXP_UNITY, 16'd1000, 16'd1000, 1'b0);
        send_pixel(32'hFFFFFFFF, 29);
        send_pixel(32'h40404040, 29);

        set_gains(rgbwb_pkg::EXP_UNITY, 16'd4000, 16'd0, 1'b0);
        send_pixel(32'hC8C8C801, 29);
        send_pixel(32'h0A0B0C0D, 29);

        set_gains(rgbwb_pkg::EXP_UNITY, 16'd0, 16'd1, 1'b0);
        send_pixel(32'hFFFFFFFF, 29);
        send_pixel(32'h7F7F7F7F, 29);

        set_gains(rgbwb_pkg::EXP_MAX, 16'd5499, 16'(-16'sd200), 1'b1);
        send_pixel(32'h01010101, 29);
        send_pixel(32'h08080808, 29);

        set_gains(16'd255, 16'h8000, 16'hF800, 1'b0);
        send_pixel(32'hFFFFFFFF, 29);
        send_pixel(32'h80818283, 29);

        for (int phase = 0; phase < 9; phase++)
        begin
            idle_pct = (phase < 3) ? 29 : (phase < 6) ? 66 : 0;
            set_gains(pick_exposure(), pick_temperature(), pick_tint(), $urandom_range(3) == 0);
            repeat (90)
                send_pixel(pixel_t'($urandom), idle_pct);
        end

        drain();
        repeat (4) @(posedge clk);
        if (gains.pending() != 0)
            gains.report_mismatch("results never seen", gains.pending(), 0);
        if (gains.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
